@@ hdl/alert_chime_sequencer_unit_defines.svh @@
// Assertion macros for the alert chime sequencer.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef ALERT_CHIME_SEQUENCER_UNIT_DEFINES_SVH
`define ALERT_CHIME_SEQUENCER_UNIT_DEFINES_SVH

// Check that a condition holds at every clock edge outside reset
`define ACS_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a consequence holds whenever its antecedent holds
`define ACS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ hdl/acs_pkg.sv @@
// Shared types, constants and phase tables for the alert chime sequencer.
// No dependencies; used by every module of the block.
package acs_pkg;

  // Item on the command channel
  typedef struct packed {
    logic       mode;
    logic [7:0] command_byte;
  } in_item_t;

  // Item on the result channel
  typedef struct packed {
    logic [1:0] tone_select;
    logic       alert_active;
    logic [2:0] stage_now;
    logic       pattern_busy;
  } out_item_t;

  // Item kinds
  localparam logic MODE_TICK    = 1'b0;
  localparam logic MODE_COMMAND = 1'b1;

  // Configuration register indexes
  localparam logic REG_TIMEOUT_MS      = 1'b0;
  localparam logic REG_REPEAT_AFTER_MS = 1'b1;

  // Register reset values
  localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
  localparam logic [15:0] REPEAT_RESET  = 16'd1000;
  localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

  // Stage codes
  localparam logic [2:0] STAGE_STOP = 3'd0;
  localparam logic [2:0] STAGE_CRIT = 3'd4;
  localparam logic [7:0] CMD_MAX    = 8'd4;

  // Tone codes
  localparam logic [1:0] TONE_SILENT = 2'd0;
  localparam logic [1:0] TONE_LOW    = 2'd1;
  localparam logic [1:0] TONE_HIGH   = 2'd2;

  // Chime phases and their lengths in ms
  localparam logic [1:0] PH_LOW  = 2'd0;
  localparam logic [1:0] PH_GAP1 = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;
  localparam logic [1:0] PH_GAP2 = 2'd3;

  localparam logic [7:0] LOW_TONE_MS  = 8'd150;
  localparam logic [7:0] GAP1_MS      = 8'd50;
  localparam logic [7:0] HIGH_TONE_MS = 8'd100;
  localparam logic [7:0] GAP2_MS      = 8'd50;

  function automatic logic [7:0] phase_len(input logic [1:0] ph);
    logic [7:0] len;
    case (ph)
      PH_LOW:  len = LOW_TONE_MS;
      PH_GAP1: len = GAP1_MS;
      PH_HIGH: len = HIGH_TONE_MS;
      default: len = GAP2_MS;
    endcase
    return len;
  endfunction

  function automatic logic [1:0] phase_tone(input logic [1:0] ph);
    logic [1:0] tone;
    case (ph)
      PH_LOW:  tone = TONE_LOW;
      PH_HIGH: tone = TONE_HIGH;
      default: tone = TONE_SILENT;
    endcase
    return tone;
  endfunction

endpackage

@@ hdl/acs_seq.sv @@
// Sequencer state, configuration registers and next-state logic.
// Depends on acs_pkg and the assertion macros header.
`include "alert_chime_sequencer_unit_defines.svh"

module acs_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_wdata,
  input  logic              step,
  input  acs_pkg::in_item_t cmd,
  output acs_pkg::out_item_t res
);

  logic [15:0] timeout_ms;
  logic [15:0] repeat_after_ms;

  logic [15:0] elapsed_ms,        elapsed_ms_next;
  logic        active_flag,       active_flag_next;
  logic [2:0]  stage_reg,         stage_reg_next;
  logic [1:0]  pattern_phase,     pattern_phase_next;
  logic [7:0]  phase_ms,          phase_ms_next;
  logic [2:0]  chimes_left,       chimes_left_next;
  logic        pattern_is_repeat, pattern_is_repeat_next;
  logic        pending_valid,     pending_valid_next;
  logic [2:0]  pending_stage,     pending_stage_next;

  logic        busy;
  logic        cmd_ok;
  logic        do_apply;
  logic [2:0]  apply_val;
  logic [7:0]  phase_inc;
  logic [15:0] elapsed_inc;

  assign busy        = (chimes_left != 3'd0);
  assign cmd_ok      = (cmd.command_byte <= acs_pkg::CMD_MAX);
  assign phase_inc   = phase_ms + 8'd1;
  assign elapsed_inc = (elapsed_ms != acs_pkg::ELAPSED_MAX) ? elapsed_ms + 16'd1 : elapsed_ms;

  // Work out the state after one item
  always_comb begin
    elapsed_ms_next        = elapsed_ms;
    active_flag_next       = active_flag;
    stage_reg_next         = stage_reg;
    pattern_phase_next     = pattern_phase;
    phase_ms_next          = phase_ms;
    chimes_left_next       = chimes_left;
    pattern_is_repeat_next = pattern_is_repeat;
    pending_valid_next     = pending_valid;
    pending_stage_next     = pending_stage;
    do_apply               = 1'b0;
    apply_val              = acs_pkg::STAGE_STOP;

    if (step) begin
      if (cmd.mode == acs_pkg::MODE_COMMAND) begin
        if (busy) begin
          // Hold the latest command until the pattern ends
          if (cmd_ok) begin
            pending_valid_next = 1'b1;
            pending_stage_next = cmd.command_byte[2:0];
          end
        end else if (cmd_ok) begin
          do_apply  = 1'b1;
          apply_val = cmd.command_byte[2:0];
        end
      end else if (busy) begin
        // Advance the chime pattern
        if (pattern_is_repeat) begin
          elapsed_ms_next = elapsed_inc;
        end
        if (phase_inc >= acs_pkg::phase_len(pattern_phase)) begin
          phase_ms_next      = 8'd0;
          pattern_phase_next = pattern_phase + 2'd1;
          if (pattern_phase == acs_pkg::PH_GAP2) begin
            chimes_left_next = chimes_left - 3'd1;
            if (chimes_left == 3'd1) begin
              pattern_is_repeat_next = 1'b0;
              if (pending_valid) begin
                pending_valid_next = 1'b0;
                pending_stage_next = acs_pkg::STAGE_STOP;
                do_apply           = 1'b1;
                apply_val          = pending_stage;
              end
            end
          end
        end else begin
          phase_ms_next = phase_inc;
        end
      end else if (active_flag) begin
        // Run the alert window: time out, or repeat the critical chimes
        elapsed_ms_next = elapsed_inc;
        if (elapsed_inc >= timeout_ms) begin
          active_flag_next = 1'b0;
          stage_reg_next   = acs_pkg::STAGE_STOP;
        end else if (stage_reg == acs_pkg::STAGE_CRIT && elapsed_inc >= repeat_after_ms) begin
          chimes_left_next       = acs_pkg::STAGE_CRIT;
          pattern_phase_next     = acs_pkg::PH_LOW;
          phase_ms_next          = 8'd0;
          pattern_is_repeat_next = 1'b1;
        end
      end
    end

    // Apply a stop or start a fresh pattern
    if (do_apply) begin
      if (apply_val == acs_pkg::STAGE_STOP) begin
        active_flag_next = 1'b0;
        stage_reg_next   = acs_pkg::STAGE_STOP;
      end else begin
        chimes_left_next       = apply_val;
        pattern_phase_next     = acs_pkg::PH_LOW;
        phase_ms_next          = 8'd0;
        pattern_is_repeat_next = 1'b0;
        stage_reg_next         = apply_val;
        active_flag_next       = 1'b1;
        elapsed_ms_next        = 16'd0;
      end
    end
  end

  // Form the result from the new state
  always_comb begin
    res.pattern_busy = (chimes_left_next != 3'd0);
    res.tone_select  = res.pattern_busy ? acs_pkg::phase_tone(pattern_phase_next)
                                        : acs_pkg::TONE_SILENT;
    res.alert_active = active_flag_next;
    res.stage_now    = stage_reg_next;
  end

  // Hold configuration and sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms        <= acs_pkg::TIMEOUT_RESET;
      repeat_after_ms   <= acs_pkg::REPEAT_RESET;
      elapsed_ms        <= 16'd0;
      active_flag       <= 1'b0;
      stage_reg         <= acs_pkg::STAGE_STOP;
      pattern_phase     <= acs_pkg::PH_LOW;
      phase_ms          <= 8'd0;
      chimes_left       <= 3'd0;
      pattern_is_repeat <= 1'b0;
      pending_valid     <= 1'b0;
      pending_stage     <= acs_pkg::STAGE_STOP;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          acs_pkg::REG_TIMEOUT_MS:      timeout_ms      <= cfg_wdata;
          acs_pkg::REG_REPEAT_AFTER_MS: repeat_after_ms <= cfg_wdata;
          default: ;
        endcase
      end
      elapsed_ms        <= elapsed_ms_next;
      active_flag       <= active_flag_next;
      stage_reg         <= stage_reg_next;
      pattern_phase     <= pattern_phase_next;
      phase_ms          <= phase_ms_next;
      chimes_left       <= chimes_left_next;
      pattern_is_repeat <= pattern_is_repeat_next;
      pending_valid     <= pending_valid_next;
      pending_stage     <= pending_stage_next;
    end
  end

  // A repeat pattern only runs in an active critical stage
  `ACS_ASSERT_IMPL(a_repeat_crit, clk, rst, pattern_is_repeat, (stage_reg == acs_pkg::STAGE_CRIT) && active_flag && busy, "repeat pattern outside active critical stage")
  // A pending command only waits behind a playing pattern
  `ACS_ASSERT_IMPL(a_pending_busy, clk, rst, pending_valid, busy, "pending command left after pattern end")
  // The phase counter stays below the longest phase
  `ACS_ASSERT_ALWAYS(a_phase_range, clk, rst, phase_ms < acs_pkg::LOW_TONE_MS, "phase counter out of range")

endmodule

@@ hdl/acs_out_buf.sv @@
// Result register with a one-entry skid stage for the result channel.
// Depends on acs_pkg and the assertion macros header.
`include "alert_chime_sequencer_unit_defines.svh"

module acs_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  acs_pkg::out_item_t push_item,
  output logic               full,
  output logic               res_valid,
  input  logic               res_stall,
  output acs_pkg::out_item_t res
);

  logic               skid_valid;
  acs_pkg::out_item_t skid;
  logic               pop;

  assign pop  = res_valid && !res_stall;
  assign full = skid_valid;

  // Move items through the result register, parking one in the skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (res_valid && !pop) begin
        skid_valid <= 1'b1;
      end
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        res <= skid;
      end
    end else if (push) begin
      if (!res_valid || pop) begin
        res <= push_item;
      end else begin
        skid <= push_item;
      end
    end
  end

  // The skid stage only fills behind a waiting result
  `ACS_ASSERT_IMPL(a_skid_behind, clk, rst, skid_valid, res_valid, "skid entry without result entry")

endmodule

@@ hdl/alert_chime_sequencer_unit.sv @@
// Top level of the alert chime sequencer: state update and result buffer.
// Depends on acs_pkg, acs_seq and acs_out_buf.
//
//  channel | direction | payload              | handshake
//  --------+-----------+----------------------+----------------------
//  cmd     | in        | acs_pkg::in_item_t   | cmd_valid / cmd_stall
//  res     | out       | acs_pkg::out_item_t  | res_valid / res_stall
//  cfg     | in        | cfg_index, cfg_wdata | cfg_wen
//
// One item is taken per cycle while cmd_stall is low; its result is held
// in the result register, or in the skid entry while res stalls. The state
// update is a single pass of logic between the sequencer registers and the
// result register. cmd_stall rises only when the result register and skid
// entry are both held by a stalled res channel. Reset is synchronous; it
// clears all but the payload; the registers return to 3000 ms and 1000 ms.

module alert_chime_sequencer_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  acs_pkg::in_item_t  cmd,
  output logic               res_valid,
  input  logic               res_stall,
  output acs_pkg::out_item_t res
);

  logic               step;
  acs_pkg::out_item_t step_res;

  assign step = cmd_valid && !cmd_stall;

  // Sequencer state and next-state logic
  acs_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .cmd       (cmd),
    .res       (step_res)
  );

  // Result register and skid stage
  acs_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_item (step_res),
    .full      (cmd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
